// File: src/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in one cycle implies consequent in the next
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition must never be seen at a clock edge
`define CHK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: src/tssg_pkg.sv
// ----------------------------------------------------------------------------
// tssg_pkg
// Types and helpers of the triangle span generator.
// ----------------------------------------------------------------------------
`default_nettype none
package tssg_pkg;

  localparam int CoordW  = 32;
  localparam int RowW    = 17;
  localparam int ProdW   = 49;
  localparam int AccW    = 66;
  localparam int EdgeXW  = 51;
  localparam int SpanW   = 16;
  localparam int LimitW  = 7;
  localparam int DivW    = 49;
  localparam logic [LimitW-1:0] MaxSpans = 7'd64;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
  } tri_in_t;

  typedef struct packed {
    logic signed [SpanW-1:0] span_left;
    logic signed [SpanW-1:0] span_right;
    logic signed [SpanW-1:0] span_row;
    logic                    last_span;
  } span_out_t;

  // one set-up triangle passed from front to back
  typedef struct packed {
    logic signed [CoordW-1:0] vx0;
    logic signed [CoordW-1:0] vx1;
    logic signed [RowW-1:0]   y0;
    logic signed [RowW-1:0]   y1;
    logic signed [RowW-1:0]   y2;
    logic signed [CoordW-1:0] s02;
    logic signed [CoordW-1:0] s01;
    logic signed [CoordW-1:0] s12;
    logic signed [ProdW-1:0]  p02;
    logic signed [ProdW-1:0]  p01;
    logic signed [ProdW-1:0]  p12;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // round to nearest integer and clamp to the span range
  function automatic logic signed [SpanW-1:0] round_sat16(input logic signed [EdgeXW-1:0] x);
    logic signed [EdgeXW:0] t;
    logic signed [EdgeXW:0] r;
    t = {x[EdgeXW-1], x} + (EdgeXW+1)'(32768);
    r = t >>> 16;
    if (r > (EdgeXW+1)'(32767))
      return 16'sh7FFF;
    else if (r < -(EdgeXW+1)'(32768))
      return 16'sh8000;
    else
      return r[SpanW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/tssg_div.sv
// ----------------------------------------------------------------------------
// tssg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tssg_div
  import tssg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DivW-1:0]   dividend,
  input  logic [CoordW-1:0] divisor,
  output logic              done,
  output logic [DivW-1:0]   quotient
);

  logic              busy_r, busy_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [DivW-1:0]   q_r, q_nxt;
  logic [CoordW-1:0] rem_r, rem_nxt;
  logic [CoordW-1:0] dvs_r, dvs_nxt;
  logic              done_r, done_nxt;
  logic [CoordW:0]   trial;

  // load on start, else one shift and compare step while busy
  always_comb begin
    trial    = {rem_r, q_r[DivW-1]};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(DivW);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CoordW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CoordW-1:0];
        q_nxt   = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// File: src/tssg_front.sv
// ----------------------------------------------------------------------------
// tssg_front
// Takes a triangle, sorts it by y, works out slopes and start products.
// ----------------------------------------------------------------------------
`default_nettype none
module tssg_front
  import tssg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  tri_in_t in_data,
  input  q_stat_t q_stat,
  output logic    q_push,
  output job_t    q_job
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SORT0 = 4'd1;
  localparam logic [3:0] ST_SORT1 = 4'd2;
  localparam logic [3:0] ST_SORT2 = 4'd3;
  localparam logic [3:0] ST_DIVGO = 4'd4;
  localparam logic [3:0] ST_DIVWT = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_PUSH  = 4'd7;

  localparam logic [1:0] E02 = 2'd0;
  localparam logic [1:0] E01 = 2'd1;
  localparam logic [1:0] E12 = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] edge_r, edge_nxt;

  logic signed [CoordW-1:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [CoordW-1:0] s02_r, s01_r, s12_r;
  logic signed [ProdW-1:0]  p02_r, p01_r, p12_r;
  logic                     neg_r, zero_r;

  logic signed [CoordW-1:0] ax, ay, bx, by, sel_s;
  logic signed [CoordW:0]   dx, dy;
  logic [CoordW:0]          dx_mag;
  logic                     div_start, div_done;
  logic [DivW-1:0]          div_q;
  logic signed [CoordW-1:0] slope;
  logic [15:0]              frac;
  logic signed [ProdW-1:0]  prod;
  logic signed [CoordW:0]   ceil0, ceil1, ceil2;

  // edge endpoints
  always_comb begin
    unique case (edge_r)
      E02:     begin ax = x0_r; ay = y0_r; bx = x2_r; by = y2_r; sel_s = s02_r; end
      E01:     begin ax = x0_r; ay = y0_r; bx = x1_r; by = y1_r; sel_s = s01_r; end
      default: begin ax = x1_r; ay = y1_r; bx = x2_r; by = y2_r; sel_s = s12_r; end
    endcase
    dx     = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
    dy     = {by[CoordW-1], by} - {ay[CoordW-1], ay};
    dx_mag = dx[CoordW] ? (CoordW+1)'(-dx) : dx;
  end

  assign div_start = (state_r == ST_DIVGO);

  tssg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dx_mag, 16'h0000}),
    .divisor  (dy[CoordW-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // sign and saturation of the quotient
  always_comb begin
    if (zero_r)
      slope = '0;
    else if (neg_r)
      slope = (div_q > DivW'(33'h080000000)) ? 32'sh80000000 : CoordW'(-div_q);
    else
      slope = (div_q > DivW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : div_q[CoordW-1:0];
  end

  // start offset below the vertex, then one product a cycle
  always_comb begin
    frac = (edge_r == E12) ? 16'(-y1_r[15:0]) : 16'(-y0_r[15:0]);
    prod = $signed({{(ProdW-CoordW){sel_s[CoordW-1]}}, sel_s})
           * $signed({{(ProdW-16){1'b0}}, frac});
  end

  // integer rows from ceiled vertex y
  always_comb begin
    ceil0 = {y0_r[CoordW-1], y0_r} + (CoordW+1)'(16'hFFFF);
    ceil1 = {y1_r[CoordW-1], y1_r} + (CoordW+1)'(16'hFFFF);
    ceil2 = {y2_r[CoordW-1], y2_r} + (CoordW+1)'(16'hFFFF);
  end

  always_comb begin
    q_job.vx0 = x0_r;
    q_job.vx1 = x1_r;
    q_job.y0  = ceil0[CoordW:16];
    q_job.y1  = ceil1[CoordW:16];
    q_job.y2  = ceil2[CoordW:16];
    q_job.s02 = s02_r;
    q_job.s01 = s01_r;
    q_job.s12 = s12_r;
    q_job.p02 = p02_r;
    q_job.p01 = p01_r;
    q_job.p12 = p12_r;
  end

  assign q_push   = (state_r == ST_PUSH) && !q_stat.full;
  assign in_stall = (state_r != ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    edge_nxt  = edge_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SORT0;
      ST_SORT0: state_nxt = ST_SORT1;
      ST_SORT1: state_nxt = ST_SORT2;
      ST_SORT2: begin state_nxt = ST_DIVGO; edge_nxt = E02; end
      ST_DIVGO: state_nxt = ST_DIVWT;
      ST_DIVWT: begin
        if (div_done) begin
          if (edge_r == E12) begin
            state_nxt = ST_MUL;
            edge_nxt  = E02;
          end else begin
            state_nxt = ST_DIVGO;
            edge_nxt  = edge_r + 2'd1;
          end
        end
      end
      ST_MUL: begin
        if (edge_r == E12) state_nxt = ST_PUSH;
        else               edge_nxt  = edge_r + 2'd1;
      end
      ST_PUSH:  if (!q_stat.full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      edge_r  <= E02;
    end else begin
      state_r <= state_nxt;
      edge_r  <= edge_nxt;
    end
  end

  // vertex capture and compare-swap sort
  always_ff @(posedge clk) begin
    priority case (1'b1)
      state_r == ST_IDLE && in_valid: begin
        x0_r <= in_data.v0_x; y0_r <= in_data.v0_y;
        x1_r <= in_data.v1_x; y1_r <= in_data.v1_y;
        x2_r <= in_data.v2_x; y2_r <= in_data.v2_y;
      end
      state_r == ST_SORT0 && y0_r > y1_r: begin
        x0_r <= x1_r; y0_r <= y1_r; x1_r <= x0_r; y1_r <= y0_r;
      end
      state_r == ST_SORT1 && y0_r > y2_r: begin
        x0_r <= x2_r; y0_r <= y2_r; x2_r <= x0_r; y2_r <= y0_r;
      end
      state_r == ST_SORT2 && y1_r > y2_r: begin
        x1_r <= x2_r; y1_r <= y2_r; x2_r <= x1_r; y2_r <= y1_r;
      end
      default: ;
    endcase
  end

  // slope and product registers
  always_ff @(posedge clk) begin
    if (state_r == ST_DIVGO) begin
      neg_r  <= dx[CoordW];
      zero_r <= (dy == '0);
    end
    if (state_r == ST_DIVWT && div_done) begin
      unique case (edge_r)
        E02:     s02_r <= slope;
        E01:     s01_r <= slope;
        default: s12_r <= slope;
      endcase
    end
    if (state_r == ST_MUL) begin
      unique case (edge_r)
        E02:     p02_r <= prod;
        E01:     p01_r <= prod;
        default: p12_r <= prod;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/tssg_queue.sv
// ----------------------------------------------------------------------------
// tssg_queue
// Short queue of set-up triangles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module tssg_queue
  import tssg_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    wr_job,
  input  logic    pop,
  output job_t    rd_job,
  output q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_job     = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

// File: src/tssg_back.sv
// ----------------------------------------------------------------------------
// tssg_back
// Walks the rows of one triangle and emits one span item per cycle unless out_stall holds the output.
// ----------------------------------------------------------------------------
`default_nettype none
module tssg_back
  import tssg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LimitW-1:0] max_spans,
  input  job_t              q_job,
  input  q_stat_t           q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output span_out_t         out_data
);

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_RUN  = 1'b1;

  logic                     state_r;
  job_t                     job_r;
  logic signed [RowW-1:0]   row_r;
  logic [LimitW-1:0]        n_r;
  logic signed [AccW-1:0]   acc_a_r, acc_b_r;
  logic                     out_valid_r;
  span_out_t                out_r;

  logic [LimitW-1:0]        limit;
  logic                     adv, is_last, upper;
  logic signed [RowW-1:0]   row_inc;
  logic signed [CoordW-1:0] base_b, s_b;
  logic signed [EdgeXW-1:0] xa, xb, xl, xr;
  logic                     start_ok;

  assign limit    = (max_spans > MaxSpans) ? MaxSpans : max_spans;
  assign start_ok = (limit != '0) && (q_job.y0 < q_job.y2);
  assign q_pop    = (state_r == BK_IDLE) && !q_stat.empty;
  assign adv      = (state_r == BK_RUN) && (!out_valid_r || !out_stall);

  // edge x values for the current row
  always_comb begin
    upper   = (row_r < job_r.y1);
    base_b  = upper ? job_r.vx0 : job_r.vx1;
    s_b     = upper ? job_r.s01 : job_r.s12;
    row_inc = row_r + RowW'(1);
    xa = {{(EdgeXW-CoordW){job_r.vx0[CoordW-1]}}, job_r.vx0}
         + {acc_a_r[AccW-1], acc_a_r[AccW-1:16]};
    xb = {{(EdgeXW-CoordW){base_b[CoordW-1]}}, base_b}
         + {acc_b_r[AccW-1], acc_b_r[AccW-1:16]};
    xl = (xa > xb) ? xb : xa;
    xr = (xa > xb) ? xa : xb;
    is_last = (row_inc >= job_r.y2) || (n_r + LimitW'(1) == limit);
  end

  // row walker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      unique case (state_r)
        BK_IDLE: if (q_pop && start_ok) state_r <= BK_RUN;
        default: if (adv && is_last)   state_r <= BK_IDLE;
      endcase
    end
    if (q_pop) begin
      job_r   <= q_job;
      row_r   <= q_job.y0;
      n_r     <= '0;
      acc_a_r <= {{(AccW-ProdW){q_job.p02[ProdW-1]}}, q_job.p02};
      acc_b_r <= (q_job.y0 < q_job.y1)
                 ? {{(AccW-ProdW){q_job.p01[ProdW-1]}}, q_job.p01}
                 : {{(AccW-ProdW){q_job.p12[ProdW-1]}}, q_job.p12};
    end else if (adv) begin
      row_r   <= row_inc;
      n_r     <= n_r + LimitW'(1);
      acc_a_r <= acc_a_r + {{(AccW-CoordW-16){job_r.s02[CoordW-1]}}, job_r.s02, 16'h0000};
      if (row_inc == job_r.y1)
        acc_b_r <= {{(AccW-ProdW){job_r.p12[ProdW-1]}}, job_r.p12};
      else
        acc_b_r <= acc_b_r + {{(AccW-CoordW-16){s_b[CoordW-1]}}, s_b, 16'h0000};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (adv)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
    if (adv) begin
      out_r.span_left  <= round_sat16(xl);
      out_r.span_right <= round_sat16(xr - EdgeXW'(1));
      out_r.span_row   <= row_r[SpanW-1:0];
      out_r.last_span  <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: src/triangle_scanline_span_generator.sv
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator
// Scanline rasteriser: one triangle in, one span item per covered row out, at most max_spans (capped at 64).
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | payload
//   in_      | in        | in_valid/in_stall  | tri_in_t (three 16.16 vertices)
//   out_     | out       | out_valid/out_stall| span_out_t (left, right, row, last)
//   cfg_     | in        | cfg_valid/cfg_ready| max_spans, 7 bit
//
// the front takes one triangle at a time and stalls in_ until it is pushed: three compare-swaps,
// three slope divisions on one divider, three multiplies, a push.
// the back emits one span per cycle unless out_stall holds the output register.
// reset clears control state and sets max_spans to 64; no clearing pass.
// out_stall holds the output register; the queue lets the front go on meanwhile.
`default_nettype none
`include "assert_macros.svh"
module triangle_scanline_span_generator
  import tssg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tri_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output span_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LimitW-1:0] cfg_data
);

  logic [LimitW-1:0] max_spans_r;
  logic              q_push, q_pop;
  job_t              q_wr_job, q_rd_job;
  q_stat_t           q_stat;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)
      max_spans_r <= MaxSpans;
    else if (cfg_valid && cfg_ready)
      max_spans_r <= cfg_data;
  end

  tssg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (q_wr_job)
  );

  tssg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .pop    (q_pop),
    .rd_job (q_rd_job),
    .stat   (q_stat)
  );

  tssg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_spans (max_spans_r),
    .q_job     (q_rd_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `CHK_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "front took a second item at once")
  `CHK_NEVER(a_no_overflow, q_push && q_stat.full, "queue push while full")
  `CHK_NEVER(a_no_underflow, q_pop && q_stat.empty, "queue pop while empty")

endmodule
`default_nettype wire
